// File: rtl/sveq_pkg.sv
package sveq_pkg;

  localparam int NUM_CUT    = 8;
  localparam int NUM_BELL   = 4;
  localparam int NUM_SLOTS  = 2 + 2 * NUM_CUT + NUM_BELL;
  localparam int LP1_SLOT   = 1 + NUM_CUT;
  localparam int BELL_START = 2 + 2 * NUM_CUT;
  localparam int NUM_COEFS  = 5;
  localparam int REG_W      = 22;
  localparam int CFG_IDX_W  = 2;

  localparam int SMP_W      = 24;
  localparam int COEF_W     = 32;
  localparam int ST_W       = 48;
  localparam int COEF_FRAC  = COEF_W - 4;
  localparam int WID_SH     = (ST_W - 8) - (SMP_W - 1);
  localparam int LO_W       = ST_W / 2;
  localparam int MUL_W      = ST_W + COEF_W + 2;

  localparam int COEF_DEPTH = NUM_SLOTS * NUM_COEFS;
  localparam int ST_DEPTH   = NUM_SLOTS * 2;
  localparam int SLOT_W     = $clog2(NUM_SLOTS + 1);
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int SA_W       = $clog2(ST_DEPTH);
  localparam int STEP_W     = 5;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 2'd1;

  localparam logic [2:0] CI_G  = 3'd0;
  localparam logic [2:0] CI_D  = 3'd1;
  localparam logic [2:0] CI_R2 = 3'd2;
  localparam logic [2:0] CI_B0 = 3'd0;
  localparam logic [2:0] CI_B1 = 3'd1;
  localparam logic [2:0] CI_B2 = 3'd2;
  localparam logic [2:0] CI_A1 = 3'd3;
  localparam logic [2:0] CI_A2 = 3'd4;

  localparam logic [ST_W:0]      OUT_RND_P = (ST_W + 1)'(1) << (WID_SH - 1);
  localparam logic [ST_W:0]      OUT_RND_N = OUT_RND_P - (ST_W + 1)'(1);
  localparam logic [MUL_W-1:0]   MUL_RND_P = MUL_W'(1) << (COEF_FRAC - 1);
  localparam logic [MUL_W-1:0]   MUL_RND_N = MUL_RND_P - MUL_W'(1);
  localparam logic [ST_W-1:0]    ST_MAX    = {1'b0, {(ST_W - 1){1'b1}}};
  localparam logic [ST_W-1:0]    ST_MIN    = {1'b1, {(ST_W - 1){1'b0}}};
  localparam logic [SMP_W-1:0]   SMP_MAX   = {1'b0, {(SMP_W - 1){1'b1}}};
  localparam logic [SMP_W-1:0]   SMP_MIN   = {1'b1, {(SMP_W - 1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_SLOT, S_LD, S_EXEC, S_CLAT, S_MULW, S_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {MP_IDLE, MP_HI, MP_RND} mul_ph_e;

  typedef enum logic [2:0] {K_HP1, K_HP2, K_LP1, K_LP2, K_BELL} kind_e;

  typedef enum logic [1:0] {OP_CF, OP_MUL, OP_ALU, OP_END} op_e;

  typedef enum logic [1:0] {CF_C, CF_G, CF_CG} cf_e;

  typedef enum logic [2:0] {R_X, R_S1, R_S2, R_A, R_B, R_H, R_P, R_Z} reg_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] cidx;
    cf_e        cf;
    reg_e       ma;
    logic       use_g;
    reg_e       dst;
    reg_e       a;
    reg_e       b;
    logic       sub;
  } uinstr_t;

  typedef struct packed {
    logic            capture;
    logic            ch_end;
    logic            ch;
    logic            st_load;
    logic            st_zero;
    logic            st_we;
    logic            cf_load;
    logic            mul_start;
    logic            alu_en;
    logic            out_load;
    logic            coef_we;
    logic [CA_W-1:0] coef_waddr;
    logic [CA_W-1:0] coef_raddr;
    logic [SA_W-1:0] st_addr;
    uinstr_t         ui;
  } sveq_cmd_t;

  typedef struct packed {
    logic mul_done;
  } sveq_sts_t;

  function automatic kind_e slot_kind(input logic [SLOT_W-1:0] slot);
    kind_e k;
    if (slot == SLOT_W'(0)) begin
      k = K_HP1;
    end else if (slot < SLOT_W'(LP1_SLOT)) begin
      k = K_HP2;
    end else if (slot == SLOT_W'(LP1_SLOT)) begin
      k = K_LP1;
    end else if (slot < SLOT_W'(BELL_START)) begin
      k = K_LP2;
    end else begin
      k = K_BELL;
    end
    return k;
  endfunction

  function automatic uinstr_t mk_end();
    uinstr_t u;
    u = '0;
    u.op = OP_END;
    return u;
  endfunction

  function automatic uinstr_t mk_cf(input logic [2:0] ci, input cf_e m);
    uinstr_t u;
    u = '0;
    u.op = OP_CF;
    u.cidx = ci;
    u.cf = m;
    return u;
  endfunction

  function automatic uinstr_t mk_mul(input reg_e a, input logic use_g);
    uinstr_t u;
    u = '0;
    u.op = OP_MUL;
    u.ma = a;
    u.use_g = use_g;
    return u;
  endfunction

  function automatic uinstr_t mk_alu(input reg_e d, input reg_e a, input reg_e b,
                                     input logic sub);
    uinstr_t u;
    u = '0;
    u.op = OP_ALU;
    u.dst = d;
    u.a = a;
    u.b = b;
    u.sub = sub;
    return u;
  endfunction

  function automatic uinstr_t ucode(input kind_e k, input logic [STEP_W-1:0] st);
    uinstr_t u;
    u = mk_end();
    unique case (k)
      K_HP2, K_LP2: begin
        unique case (st)
          5'd0:  u = mk_cf(CI_G, CF_G);
          5'd1:  u = mk_cf(CI_R2, CF_CG);
          5'd2:  u = mk_mul(R_S1, 1'b0);
          5'd3:  u = mk_alu(R_A, R_X, R_P, 1'b1);
          5'd4:  u = mk_alu(R_A, R_A, R_S2, 1'b1);
          5'd5:  u = mk_cf(CI_D, CF_C);
          5'd6:  u = mk_mul(R_A, 1'b0);
          5'd7:  u = mk_alu(R_H, R_P, R_Z, 1'b0);
          5'd8:  u = mk_mul(R_H, 1'b1);
          5'd9:  u = mk_alu(R_A, R_P, R_S1, 1'b0);
          5'd10: u = mk_alu(R_S1, R_A, R_P, 1'b0);
          5'd11: u = mk_mul(R_A, 1'b1);
          5'd12: u = mk_alu(R_B, R_P, R_S2, 1'b0);
          5'd13: u = mk_alu(R_S2, R_B, R_P, 1'b0);
          5'd14: begin
            if (k == K_HP2) begin
              u = mk_alu(R_X, R_H, R_Z, 1'b0);
            end else begin
              u = mk_alu(R_X, R_B, R_Z, 1'b0);
            end
          end
          default: u = mk_end();
        endcase
      end
      K_HP1: begin
        unique case (st)
          5'd0:    u = mk_cf(CI_G, CF_G);
          5'd1:    u = mk_cf(CI_D, CF_C);
          5'd2:    u = mk_alu(R_A, R_X, R_S1, 1'b1);
          5'd3:    u = mk_mul(R_A, 1'b0);
          5'd4:    u = mk_alu(R_H, R_P, R_Z, 1'b0);
          5'd5:    u = mk_mul(R_H, 1'b1);
          5'd6:    u = mk_alu(R_A, R_P, R_P, 1'b0);
          5'd7:    u = mk_alu(R_S1, R_S1, R_A, 1'b0);
          5'd8:    u = mk_alu(R_X, R_H, R_Z, 1'b0);
          default: u = mk_end();
        endcase
      end
      K_LP1: begin
        unique case (st)
          5'd0:    u = mk_cf(CI_G, CF_G);
          5'd1:    u = mk_cf(CI_D, CF_C);
          5'd2:    u = mk_mul(R_X, 1'b1);
          5'd3:    u = mk_alu(R_A, R_P, R_S1, 1'b0);
          5'd4:    u = mk_mul(R_A, 1'b0);
          5'd5:    u = mk_alu(R_H, R_P, R_Z, 1'b0);
          5'd6:    u = mk_alu(R_A, R_H, R_S1, 1'b1);
          5'd7:    u = mk_alu(R_S1, R_H, R_A, 1'b0);
          5'd8:    u = mk_alu(R_X, R_H, R_Z, 1'b0);
          default: u = mk_end();
        endcase
      end
      K_BELL: begin
        unique case (st)
          5'd0:    u = mk_cf(CI_B0, CF_C);
          5'd1:    u = mk_mul(R_X, 1'b0);
          5'd2:    u = mk_alu(R_H, R_P, R_S1, 1'b0);
          5'd3:    u = mk_cf(CI_B1, CF_C);
          5'd4:    u = mk_mul(R_X, 1'b0);
          5'd5:    u = mk_alu(R_A, R_P, R_Z, 1'b0);
          5'd6:    u = mk_cf(CI_A1, CF_C);
          5'd7:    u = mk_mul(R_H, 1'b0);
          5'd8:    u = mk_alu(R_A, R_A, R_P, 1'b1);
          5'd9:    u = mk_alu(R_S1, R_A, R_S2, 1'b0);
          5'd10:   u = mk_cf(CI_B2, CF_C);
          5'd11:   u = mk_mul(R_X, 1'b0);
          5'd12:   u = mk_alu(R_A, R_P, R_Z, 1'b0);
          5'd13:   u = mk_cf(CI_A2, CF_C);
          5'd14:   u = mk_mul(R_H, 1'b0);
          5'd15:   u = mk_alu(R_S2, R_A, R_P, 1'b1);
          5'd16:   u = mk_alu(R_X, R_H, R_Z, 1'b0);
          default: u = mk_end();
        endcase
      end
      default: u = mk_end();
    endcase
    return u;
  endfunction

  function automatic logic [ST_W-1:0] sat_st(input logic [ST_W:0] s);
    logic [ST_W-1:0] r;
    if (s[ST_W] != s[ST_W-1]) begin
      r = s[ST_W] ? ST_MIN : ST_MAX;
    end else begin
      r = s[ST_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ST_W-1:0] widen(input logic [SMP_W-1:0] s);
    return {{(ST_W - SMP_W - WID_SH){s[SMP_W-1]}}, s, {WID_SH{1'b0}}};
  endfunction

  function automatic logic [SMP_W-1:0] round_out(input logic [ST_W-1:0] x);
    logic [ST_W:0]        t;
    logic [ST_W-WID_SH:0] q;
    logic [SMP_W-1:0]     r;
    t = {x[ST_W-1], x} + (x[ST_W-1] ? OUT_RND_N : OUT_RND_P);
    q = t[ST_W:WID_SH];
    if ((&q[ST_W-WID_SH:SMP_W-1]) || !(|q[ST_W-WID_SH:SMP_W-1])) begin
      r = q[SMP_W-1:0];
    end else begin
      r = q[ST_W-WID_SH] ? SMP_MIN : SMP_MAX;
    end
    return r;
  endfunction

endpackage

// File: rtl/sveq_ifs.sv
interface sveq_req_if import sveq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [SMP_W-1:0]  sample_left;
  logic signed [SMP_W-1:0]  sample_right;
  logic                     last_in_block;
  logic [4:0]               slot;
  logic [2:0]               coef_index;
  logic signed [COEF_W-1:0] coef_value;

  modport source (output valid, kind, sample_left, sample_right, last_in_block, slot,
                  coef_index, coef_value, input ready);
  modport sink (input valid, kind, sample_left, sample_right, last_in_block, slot,
                coef_index, coef_value, output ready);
endinterface

interface sveq_res_if import sveq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] out_left;
  logic signed [SMP_W-1:0] out_right;
  logic                    last_in_block_out;

  modport source (output valid, out_left, out_right, last_in_block_out, input ready);
  modport sink (input valid, out_left, out_right, last_in_block_out, output ready);
endinterface

// File: rtl/stereo_svf_biquad_eq_cascade.sv
// Stereo equalizer chain of 22 sections (high-pass, low-pass, bells) that
// takes one request at a time: a coefficient write request is taken while
// the block is idle, and a sample request occupies the block while its left
// and then its right channel pass through every enabled, unbypassed section.
// All products go through one shared 48 x 33 multiplier, and coefficients
// are fetched from a store with one write port and one read port. Results
// are held in an output register, so the next request is taken while a
// result still waits.
module stereo_svf_biquad_eq_cascade import sveq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sveq_req_if.sink             req_i,
  sveq_res_if.source           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i
);

  sveq_cmd_t cmd;
  sveq_sts_t sts;

  sveq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_kind_i  (req_i.kind),
    .req_slot_i  (req_i.slot),
    .req_cidx_i  (req_i.coef_index),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sveq_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .sample_left_i       (req_i.sample_left),
    .sample_right_i      (req_i.sample_right),
    .last_in_block_i     (req_i.last_in_block),
    .coef_value_i        (req_i.coef_value),
    .out_left_o          (res_o.out_left),
    .out_right_o         (res_o.out_right),
    .last_in_block_out_o (res_o.last_in_block_out)
  );

endmodule

// File: rtl/sveq_ram.sv
module sveq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/sveq_mul.sv
module sveq_mul import sveq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ST_W-1:0]   a_i,
  input  logic [COEF_W:0]   c_i,
  output logic              done_o,
  output logic [ST_W-1:0]   p_o
);

  mul_ph_e ph_q, ph_d;
  logic signed [LO_W+COEF_W+1:0]    lo_d, lo_q;
  logic signed [ST_W-LO_W+COEF_W:0] hi_d;
  logic [MUL_W-1:0]                 full_d, full_q;
  logic [MUL_W-1:0]                 rnd;
  logic [MUL_W-COEF_FRAC-1:0]       q;

  assign lo_d   = $signed({1'b0, a_i[LO_W-1:0]}) * $signed(c_i);
  assign hi_d   = $signed(a_i[ST_W-1:LO_W]) * $signed(c_i);
  assign full_d = {hi_d[ST_W-LO_W+COEF_W], hi_d, {LO_W{1'b0}}} + MUL_W'(lo_q);
  assign rnd    = full_q + (full_q[MUL_W-1] ? MUL_RND_N : MUL_RND_P);
  assign q      = rnd[MUL_W-1:COEF_FRAC];

  always_comb begin
    if ((&q[MUL_W-COEF_FRAC-1:ST_W-1]) || !(|q[MUL_W-COEF_FRAC-1:ST_W-1])) begin
      p_o = q[ST_W-1:0];
    end else begin
      p_o = q[MUL_W-COEF_FRAC-1] ? ST_MIN : ST_MAX;
    end
  end

  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      MP_IDLE: if (start_i) begin
        ph_d = MP_HI;
      end
      MP_HI:   ph_d = MP_RND;
      MP_RND:  ph_d = MP_IDLE;
      default: ph_d = MP_IDLE;
    endcase
  end

  assign done_o = (ph_q == MP_RND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= MP_IDLE;
    end else begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == MP_IDLE) begin
      lo_q <= lo_d;
    end
    if (ph_q == MP_HI) begin
      full_q <= full_d;
    end
  end

endmodule

// File: rtl/sveq_dp.sv
module sveq_dp import sveq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sveq_cmd_t         cmd_i,
  output sveq_sts_t         sts_o,
  input  logic [SMP_W-1:0]  sample_left_i,
  input  logic [SMP_W-1:0]  sample_right_i,
  input  logic              last_in_block_i,
  input  logic [COEF_W-1:0] coef_value_i,
  output logic [SMP_W-1:0]  out_left_o,
  output logic [SMP_W-1:0]  out_right_o,
  output logic              last_in_block_out_o
);

  logic [ST_W-1:0]   x_q, s1_q, s2_q, a_q, b_q, h_q, p_q;
  logic [COEF_W:0]   g_q, c_q;
  logic [SMP_W-1:0]  sr_q, yl_q, yr_q, ol_q, or_q;
  logic              last_q, olast_q;
  logic [COEF_W-1:0] coef_rd;
  logic [2*ST_W-1:0] st_rd;
  logic [ST_W-1:0]   alu_a, alu_b, mul_a, mul_p, alu_r;
  logic [ST_W:0]     sum;
  logic [COEF_W:0]   coef_ext;
  logic              mul_done;

  function automatic logic [ST_W-1:0] pick(input reg_e r, input logic [ST_W-1:0] x,
      input logic [ST_W-1:0] s1, input logic [ST_W-1:0] s2, input logic [ST_W-1:0] a,
      input logic [ST_W-1:0] b, input logic [ST_W-1:0] h, input logic [ST_W-1:0] p);
    logic [ST_W-1:0] v;
    unique case (r)
      R_X:  v = x;
      R_S1: v = s1;
      R_S2: v = s2;
      R_A:  v = a;
      R_B:  v = b;
      R_H:  v = h;
      R_P:  v = p;
      R_Z:  v = '0;
    endcase
    return v;
  endfunction

  sveq_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.coef_we),
    .waddr_i (cmd_i.coef_waddr),
    .wdata_i (coef_value_i),
    .raddr_i (cmd_i.coef_raddr),
    .rdata_o (coef_rd)
  );

  sveq_ram #(.WIDTH(2 * ST_W), .DEPTH(ST_DEPTH)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.st_we),
    .waddr_i (cmd_i.st_addr),
    .wdata_i ({s2_q, s1_q}),
    .raddr_i (cmd_i.st_addr),
    .rdata_o (st_rd)
  );

  assign alu_a    = pick(cmd_i.ui.a, x_q, s1_q, s2_q, a_q, b_q, h_q, p_q);
  assign alu_b    = pick(cmd_i.ui.b, x_q, s1_q, s2_q, a_q, b_q, h_q, p_q);
  assign mul_a    = pick(cmd_i.ui.ma, x_q, s1_q, s2_q, a_q, b_q, h_q, p_q);
  assign sum      = cmd_i.ui.sub ? ({alu_a[ST_W-1], alu_a} - {alu_b[ST_W-1], alu_b})
                                 : ({alu_a[ST_W-1], alu_a} + {alu_b[ST_W-1], alu_b});
  assign alu_r    = sat_st(sum);
  assign coef_ext = {coef_rd[COEF_W-1], coef_rd};

  sveq_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .c_i     (cmd_i.ui.use_g ? g_q : c_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign sts_o.mul_done = mul_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sr_q   <= sample_right_i;
      last_q <= last_in_block_i;
      x_q    <= widen(sample_left_i);
    end
    if (cmd_i.ch_end) begin
      if (!cmd_i.ch) begin
        yl_q <= round_out(x_q);
        x_q  <= widen(sr_q);
      end else begin
        yr_q <= round_out(x_q);
      end
    end
    if (cmd_i.st_load) begin
      s1_q <= cmd_i.st_zero ? '0 : st_rd[ST_W-1:0];
      s2_q <= cmd_i.st_zero ? '0 : st_rd[2*ST_W-1:ST_W];
    end
    if (cmd_i.cf_load) begin
      unique case (cmd_i.ui.cf)
        CF_G:    g_q <= coef_ext;
        CF_C:    c_q <= coef_ext;
        CF_CG:   c_q <= coef_ext + g_q;
        default: c_q <= coef_ext;
      endcase
    end
    if (mul_done) begin
      p_q <= mul_p;
    end
    if (cmd_i.alu_en) begin
      unique case (cmd_i.ui.dst)
        R_X:     x_q  <= alu_r;
        R_S1:    s1_q <= alu_r;
        R_S2:    s2_q <= alu_r;
        R_A:     a_q  <= alu_r;
        R_B:     b_q  <= alu_r;
        R_H:     h_q  <= alu_r;
        R_P:     p_q  <= alu_r;
        R_Z:     p_q  <= p_q;
      endcase
    end
    if (cmd_i.out_load) begin
      ol_q    <= yl_q;
      or_q    <= yr_q;
      olast_q <= last_q;
    end
  end

  assign out_left_o          = ol_q;
  assign out_right_o         = or_q;
  assign last_in_block_out_o = olast_q;

endmodule

// File: rtl/sveq_ctrl.sv
module sveq_ctrl import sveq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic                 req_kind_i,
  input  logic [4:0]           req_slot_i,
  input  logic [2:0]           req_cidx_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  input  sveq_sts_t            sts_i,
  output sveq_cmd_t            cmd_o
);

  ctrl_state_e         state_q, state_d;
  logic [REG_W-1:0]    en_q, byp_q, prev_q, prev_d, rise;
  logic [ST_DEPTH-1:0] valid_q, valid_d, rise_mask;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                ch_q, ch_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                res_valid_q, res_valid_d;
  uinstr_t             ui;

  assign ui   = ucode(slot_kind(slot_q), step_q);
  assign rise = en_q & ~prev_q;

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      rise_mask[2*s]   = rise[s];
      rise_mask[2*s+1] = rise[s];
    end
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    ch_d        = ch_q;
    step_d      = step_q;
    prev_d      = prev_q;
    valid_d     = valid_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.ui    = ui;
    cmd_o.ch    = ch_q;
    cmd_o.st_addr    = {slot_q, ch_q};
    cmd_o.coef_raddr = CA_W'({slot_q, 2'b00}) + CA_W'(slot_q) + CA_W'(ui.cidx);
    cmd_o.coef_waddr = CA_W'({req_slot_i, 2'b00}) + CA_W'(req_slot_i) + CA_W'(req_cidx_i);
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_kind_i == KIND_COEF) begin
            cmd_o.coef_we = (req_slot_i < 5'(NUM_SLOTS)) && (req_cidx_i < 3'(NUM_COEFS));
          end else begin
            cmd_o.capture = 1'b1;
            prev_d  = en_q;
            valid_d = valid_q & ~rise_mask;
            slot_d  = '0;
            ch_d    = 1'b0;
            state_d = S_SLOT;
          end
        end
      end
      S_SLOT: begin
        if (slot_q == SLOT_W'(NUM_SLOTS)) begin
          cmd_o.ch_end = 1'b1;
          if (ch_q) begin
            state_d = S_DONE;
          end else begin
            ch_d   = 1'b1;
            slot_d = '0;
          end
        end else if (en_q[slot_q] && !byp_q[slot_q]) begin
          state_d = S_LD;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      S_LD: begin
        cmd_o.st_load = 1'b1;
        cmd_o.st_zero = !valid_q[{slot_q, ch_q}];
        step_d  = '0;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (ui.op)
          OP_CF:  state_d = S_CLAT;
          OP_MUL: begin
            cmd_o.mul_start = 1'b1;
            state_d = S_MULW;
          end
          OP_ALU: begin
            cmd_o.alu_en = 1'b1;
            step_d = step_q + 1'b1;
          end
          OP_END: begin
            cmd_o.st_we = 1'b1;
            valid_d[{slot_q, ch_q}] = 1'b1;
            slot_d  = slot_q + 1'b1;
            state_d = S_SLOT;
          end
        endcase
      end
      S_CLAT: begin
        cmd_o.cf_load = 1'b1;
        step_d  = step_q + 1'b1;
        state_d = S_EXEC;
      end
      S_MULW: begin
        if (sts_i.mul_done) begin
          step_d  = step_q + 1'b1;
          state_d = S_EXEC;
        end
      end
      S_DONE: begin
        if (!res_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.out_load) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      valid_q     <= '0;
      slot_q      <= '0;
      ch_q        <= 1'b0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      valid_q     <= valid_d;
      slot_q      <= slot_d;
      ch_q        <= ch_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= '0;
      byp_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ENABLE) begin
        en_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_BYPASS) begin
        byp_q <= cfg_wdata_i;
      end
    end
  end

`ifndef SYNTH
  a_mul_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MULW && sts_i.mul_done) |=> state_q == S_EXEC)
    else $error("sequencer did not resume after a product was ready");

  a_sample_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && req_kind_i == KIND_SAMPLE) |=> state_q == S_SLOT)
    else $error("sample request did not start the section walk");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(NUM_SLOTS))
    else $error("slot counter ran past the chain");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> res_valid_o)
    else $error("result register loaded without raising valid");
`endif

endmodule

// File: dv/sveq_chain_checker.sv
module sveq_chain_checker import sveq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  sveq_req_if              req_i,
  sveq_res_if              res_i,
  input  logic             cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o
);

  localparam longint SMAX = (longint'(1) << (ST_W - 1)) - 1;
  localparam longint OMAX = (longint'(1) << (SMP_W - 1)) - 1;

  typedef struct {
    logic [SMP_W-1:0] left;
    logic [SMP_W-1:0] right;
    logic             last;
  } eq_out_t;

  eq_out_t          expected_q[$];
  longint           coef_mem[COEF_DEPTH];
  longint           integ1[ST_DEPTH];
  longint           integ2[ST_DEPTH];
  logic [REG_W-1:0] enable_r, bypass_r, prev_enable_r;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    results_o = 0;
    enable_r = '0;
    bypass_r = '0;
    prev_enable_r = '0;
    foreach (coef_mem[i]) coef_mem[i] = 0;
    foreach (integ1[i]) begin
      integ1[i] = 0;
      integ2[i] = 0;
    end
  end

  function automatic longint clip(longint v);
    if (v > SMAX) return SMAX;
    if (v < -SMAX - 1) return -SMAX - 1;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint c);
    logic [127:0] m;
    bit neg;
    longint unsigned ma, mc;
    neg = (a < 0) != (c < 0);
    ma = (a < 0) ? -a : a;
    mc = (c < 0) ? -c : c;
    m = 128'(ma) * 128'(mc);
    m = (m + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
    if (neg) return (m > 128'(SMAX)) ? -SMAX - 1 : -longint'(m[63:0]);
    return (m > 128'(SMAX)) ? SMAX : longint'(m[63:0]);
  endfunction

  function automatic longint run_section(int s, int ch, longint x);
    longint s1, s2, y, hp, v, lp, g, rg, tmp, gh, bp, gb;
    int b;
    b = s * NUM_COEFS;
    s1 = integ1[s * 2 + ch];
    s2 = integ2[s * 2 + ch];
    if (s >= BELL_START) begin
      y = clip(qmul(x, coef_mem[b + CI_B0]) + s1);
      integ1[s * 2 + ch] = clip(clip(qmul(x, coef_mem[b + CI_B1]) -
                                     qmul(y, coef_mem[b + CI_A1])) + s2);
      integ2[s * 2 + ch] = clip(qmul(x, coef_mem[b + CI_B2]) - qmul(y, coef_mem[b + CI_A2]));
      return y;
    end
    if (s == 0) begin
      hp = qmul(clip(x - s1), coef_mem[b + CI_D]);
      v = qmul(hp, coef_mem[b + CI_G]);
      integ1[s * 2 + ch] = clip(s1 + clip(v + v));
      return hp;
    end
    if (s == LP1_SLOT) begin
      lp = qmul(clip(qmul(x, coef_mem[b + CI_G]) + s1), coef_mem[b + CI_D]);
      integ1[s * 2 + ch] = clip(lp + clip(lp - s1));
      return lp;
    end
    g = coef_mem[b + CI_G];
    rg = coef_mem[b + CI_R2] + g;
    tmp = clip(clip(x - qmul(s1, rg)) - s2);
    hp = qmul(tmp, coef_mem[b + CI_D]);
    gh = qmul(hp, g);
    bp = clip(gh + s1);
    gb = qmul(bp, g);
    lp = clip(gb + s2);
    integ1[s * 2 + ch] = clip(bp + gh);
    integ2[s * 2 + ch] = clip(lp + gb);
    return (s < LP1_SLOT) ? hp : lp;
  endfunction

  function automatic logic [SMP_W-1:0] to_sample(longint x);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + (longint'(1) << (WID_SH - 1))) >>> WID_SH;
    if (x < 0) return (m > OMAX) ? SMP_W'(-OMAX - 1) : SMP_W'(-m);
    return (m > OMAX) ? SMP_W'(OMAX) : SMP_W'(m);
  endfunction

  function automatic eq_out_t filter_pair(logic signed [SMP_W-1:0] l,
                                          logic signed [SMP_W-1:0] r, logic last);
    eq_out_t o;
    longint x[2];
    logic [REG_W-1:0] rising;
    rising = enable_r & ~prev_enable_r;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (rising[s]) begin
        for (int ch = 0; ch < 2; ch++) begin
          integ1[s * 2 + ch] = 0;
          integ2[s * 2 + ch] = 0;
        end
      end
    end
    prev_enable_r = enable_r;
    x[0] = longint'(l) <<< WID_SH;
    x[1] = longint'(r) <<< WID_SH;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (enable_r[s] && !bypass_r[s]) begin
        for (int ch = 0; ch < 2; ch++) x[ch] = run_section(s, ch, x[ch]);
      end
    end
    o.left = to_sample(x[0]);
    o.right = to_sample(x[1]);
    o.last = last;
    return o;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    eq_out_t e;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ENABLE) enable_r = cfg_wdata_i;
        else if (cfg_idx_i == CFG_BYPASS) bypass_r = cfg_wdata_i;
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.kind == KIND_COEF) begin
          if (req_i.slot < NUM_SLOTS && req_i.coef_index < NUM_COEFS)
            coef_mem[req_i.slot * NUM_COEFS + req_i.coef_index] = longint'(req_i.coef_value);
        end else begin
          expected_q.push_back(filter_pair(req_i.sample_left, req_i.sample_right,
                                           req_i.last_in_block));
        end
      end
      if (res_i.valid && res_i.ready) begin
        results_o++;
        if (expected_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          e = expected_q.pop_front();
          if (res_i.out_left !== e.left)
            report($sformatf("out_left %h, expected %h", res_i.out_left, e.left));
          if (res_i.out_right !== e.right)
            report($sformatf("out_right %h, expected %h", res_i.out_right, e.right));
          if (res_i.last_in_block_out !== e.last)
            report($sformatf("last_in_block_out %b, expected %b",
                             res_i.last_in_block_out, e.last));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: dv/tb_stereo_svf_biquad_eq_cascade.sv
module tb_stereo_svf_biquad_eq_cascade;
  import sveq_pkg::*;

  localparam int LIMIT = 6000000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [REG_W-1:0] ALL_ON = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [REG_W-1:0] cfg_wdata = '0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int fails, pending, results;
  int cycles = 0;
  int n_samples = 0;
  int n_writes = 0;

  sveq_req_if req();
  sveq_res_if res();

  stereo_svf_biquad_eq_cascade u_top (
    .clk_i(clk), .rst_ni(rst_n), .req_i(req), .res_o(res),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  sveq_chain_checker u_check (
    .clk_i(clk), .rst_ni(rst_n), .req_i(req), .res_i(res),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fails), .pending_o(pending), .results_o(results)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    res.ready <= ($urandom_range(99) >= rx_idle_pct);
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.kind = KIND_SAMPLE;
    req.sample_left = '0;
    req.sample_right = '0;
    req.last_in_block = 1'b0;
    req.slot = '0;
    req.coef_index = '0;
    req.coef_value = '0;
    res.ready = 1'b0;
  end

  task automatic push(logic kind, logic [SMP_W-1:0] l, logic [SMP_W-1:0] r, logic last,
                      logic [4:0] slot, logic [2:0] ci, logic [COEF_W-1:0] cv);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= kind;
    req.sample_left <= l;
    req.sample_right <= r;
    req.last_in_block <= last;
    req.slot <= slot;
    req.coef_index <= ci;
    req.coef_value <= cv;
    do @(posedge clk); while (!req.ready);
    if (kind == KIND_SAMPLE) n_samples++;
    else n_writes++;
  endtask

  task automatic sample(logic [SMP_W-1:0] l, logic [SMP_W-1:0] r);
    push(KIND_SAMPLE, l, r, 1'($urandom), 5'($urandom), 3'($urandom), $urandom);
  endtask

  task automatic coef(logic [4:0] slot, logic [2:0] ci, logic [COEF_W-1:0] cv);
    push(KIND_COEF, 24'($urandom), 24'($urandom), 1'($urandom), slot, ci, cv);
  endtask

  function automatic logic [COEF_W-1:0] sane_coef(int s, int ci);
    if (s >= BELL_START) begin
      if (ci == CI_B0) return $urandom_range(1 << 29, 1 << 27);
      return COEF_W'($signed($urandom_range(1 << 27)) - (1 << 26));
    end
    if (ci == CI_R2) return $urandom_range(1 << 29);
    return $urandom_range(1 << 28, 1 << 20);
  endfunction

  function automatic logic [SMP_W-1:0] rnd_sample();
    case ($urandom_range(7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_regs(logic [REG_W-1:0] en, logic [REG_W-1:0] byp);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_ENABLE;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_idx <= CFG_BYPASS;
    cfg_wdata <= byp;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int n);
    int s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) begin
        sample(rnd_sample(), rnd_sample());
      end else begin
        s = $urandom_range(NUM_SLOTS - 1);
        case ($urandom_range(9))
          0: coef(5'($urandom_range(31, NUM_SLOTS)), 3'($urandom), $urandom);
          1: coef(5'(s), 3'($urandom_range(7, NUM_COEFS)), $urandom);
          2: coef(5'(s), 3'($urandom_range(NUM_COEFS - 1)), $urandom);
          default: begin
            s = $urandom_range(NUM_COEFS - 1);
            coef(5'($urandom_range(NUM_SLOTS - 1)), 3'(s), '0);
          end
        endcase
      end
    end
  endtask

  task automatic fix_coefs();
    for (int s = 0; s < NUM_SLOTS; s++)
      for (int c = 0; c < NUM_COEFS; c++) coef(5'(s), 3'(c), sane_coef(s, c));
  endtask

  initial begin
    logic [REG_W-1:0] en;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fix_coefs();
    sample(SMP_MAX, SMP_MIN);
    set_regs(ALL_ON, '0);
    sample(SMP_MAX, SMP_MAX);
    sample(SMP_MIN, SMP_MIN);
    sample('0, SMP_MAX);
    sample(24'h555555, 24'hAAAAAA);
    coef(5'd31, CI_G, 32'h7FFFFFFF);
    coef(5'(NUM_SLOTS), CI_D, 32'h80000000);
    coef(5'd3, 3'd7, 32'h7FFFFFFF);
    coef(5'd20, CI_B0, 32'h7FFFFFFF);
    coef(5'd2, CI_D, 32'h80000000);
    sample(SMP_MAX, SMP_MIN);
    sample(24'hAAAAAA, 24'h555555);
    set_regs(ALL_ON, ALL_ON);
    sample(SMP_MIN, SMP_MAX);
    sample(24'h000001, 24'hFFFFFF);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SPARE;
    cfg_wdata <= '0;
    @(posedge clk);
    cfg_we <= 1'b0;
    fix_coefs();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 62 : 0;
      rx_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 6 : 0;
      for (int k = 0; k < 4; k++) begin
        if (k == 3) begin
          set_regs(ALL_ON, 22'($urandom) & 22'($urandom));
          random_items(15);
        end else begin
          en = 22'($urandom) & 22'($urandom) & 22'($urandom);
          set_regs(en, 22'($urandom) & 22'($urandom));
          random_items(60);
        end
      end
    end
    set_regs('0, '0);
    random_items(20);

    drain();
    repeat (1400) @(posedge clk);
    $display("Sent %0d sample requests and %0d coefficient writes; %0d results checked.",
             n_samples, n_writes, results);
    $display("Covered all sections on, all bypassed, sparse enables and three idle mixes.");
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
